// File: rtl/core/page_table_walk_with_eviction_macros.svh
// Assertion macros used by the checker file of the page table walker.
`ifndef PAGE_TABLE_WALK_WITH_EVICTION_MACROS_SVH
`define PAGE_TABLE_WALK_WITH_EVICTION_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define PTW_ASSERT_NOW(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("%m: check failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define PTW_ASSERT_NEXT(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("%m: check failed");

`endif

// File: rtl/core/ptw_pkg.sv
// Shared types and default constants of the page table walker.
package ptw_pkg;

    localparam int OFFSET_BITS_DEF  = 4;
    localparam int TABLE_LEVELS_DEF = 3;
    localparam int FRAME_COUNT_DEF  = 64;

    localparam logic REQ_READ  = 1'b0;
    localparam logic REQ_WRITE = 1'b1;

    typedef struct packed {
        logic               req_type;
        logic [31:0]        virt_addr;
        logic signed [31:0] write_data;
    } ptw_req_t;

    typedef struct packed {
        logic               access_ok;
        logic signed [31:0] read_data;
    } ptw_rsp_t;

endpackage

// File: rtl/core/page_table_walk_with_eviction.sv
// Top level of the page table walker with frame allocation and page eviction.
//
//   channel  | direction | handshake            | payload
//   request  | in        | req_valid/req_ready  | req (ptw_req_t)
//   response | out       | rsp_valid/rsp_ready  | rsp (ptw_rsp_t)
//
// A read that hits at every level is bound by the registered read of the frame memory at
// each table level and at the data word; a write skips the read of the data word.
// A missing entry adds a scan of the reachable table entries, a second such scan when no
// fresh frame is left, and a word-by-word copy of the evicted page to the swap memory.
// After reset every entry of the swap valid memory is cleared before a request is taken.
// A new request is accepted while a finished response waits in the output register.
module page_table_walk_with_eviction
    import ptw_pkg::*;
#(
    parameter int OFFSET_BITS  = OFFSET_BITS_DEF,
    parameter int TABLE_LEVELS = TABLE_LEVELS_DEF,
    parameter int FRAME_COUNT  = FRAME_COUNT_DEF
) (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_ready,
    input  ptw_req_t req,
    output logic     rsp_valid,
    input  logic     rsp_ready,
    output ptw_rsp_t rsp
);

    localparam int OB    = OFFSET_BITS;
    localparam int L     = TABLE_LEVELS;
    localparam int PB    = OB * L;
    localparam int VB    = OB * (L + 1);
    localparam int FB    = $clog2(FRAME_COUNT);
    localparam int MA    = FB + OB;
    localparam int LVL_W = (L > 1) ? $clog2(L) : 1;

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_WALK_RD, S_WALK_CHK, S_SCAN_RD, S_SCAN_CHK, S_SCAN_NEXT,
        S_MAX_DONE, S_CP_RD, S_CP_WR, S_SV_SET, S_UNLINK, S_LINK, S_TCLR, S_SV_RD,
        S_SV_CHK, S_RS_RD, S_RS_WR, S_SV_CLR, S_ADV, S_ACC, S_ACC_RD, S_FIN
    } state_t;

    function automatic logic [MA-1:0] faddr(input logic [31:0] f, input logic [OB-1:0] o);
        return {f[FB-1:0], o};
    endfunction

    function automatic logic in_range(input logic [31:0] f);
        return f < 32'(FRAME_COUNT);
    endfunction

    state_t             state_reg, state_next;
    logic               rsp_valid_reg, rsp_valid_next;
    logic [PB-1:0]      clr_reg, clr_next;
    logic [LVL_W-1:0]   lv_reg, lv_next;
    logic [LVL_W-1:0]   d_reg, d_next;
    logic [OB-1:0]      cnt_reg, cnt_next;
    logic               max_mode_reg, max_mode_next;
    logic               have_victim_reg, have_victim_next;
    logic               unlink_valid_reg, unlink_valid_next;
    logic               rd_ok_reg, rd_ok_next;
    logic               emp_reg [L];
    logic               emp_next [L];

    logic [31:0]        va_reg, va_next;
    logic               type_reg, type_next;
    logic [31:0]        wdata_reg, wdata_next;
    logic [31:0]        cur_reg, cur_next;
    logic [31:0]        new_reg, new_next;
    logic [31:0]        top_reg, top_next;
    logic [31:0]        guard_reg, guard_next;
    logic [PB-1:0]      victim_page_reg, victim_page_next;
    logic [PB-1:0]      victim_dist_reg, victim_dist_next;
    logic [31:0]        pick_reg, pick_next;
    logic [MA-1:0]      unlink_addr_reg, unlink_addr_next;
    logic               res_ok_reg, res_ok_next;
    logic signed [31:0] res_data_reg, res_data_next;
    ptw_rsp_t           rsp_reg, rsp_next;
    logic [31:0]        frm_reg [L];
    logic [31:0]        frm_next [L];
    logic [OB-1:0]      idx_reg [L];
    logic [OB-1:0]      idx_next [L];
    logic [MA-1:0]      ptr_reg [L];
    logic [MA-1:0]      ptr_next [L];

    logic               fm_we;
    logic [MA-1:0]      fm_addr;
    logic [31:0]        fm_wdata, fm_rdata;
    logic               sw_we;
    logic [VB-1:0]      sw_addr;
    logic [31:0]        sw_wdata, sw_rdata;
    logic               sv_we;
    logic [PB-1:0]      sv_addr;
    logic [0:0]         sv_wdata, sv_rdata;

    logic [31:0]        entry;
    logic [OB-1:0]      walk_idx;
    logic [OB-1:0]      offset;
    logic [PB-1:0]      page;
    logic [MA-1:0]      slot_addr;
    logic               slot_ok;
    logic [MA-1:0]      scan_addr;
    logic               scan_ok;
    logic [PB-1:0]      pg;
    logic [PB-1:0]      dist_a, dist_b, pg_dist;
    logic [32:0]        top_inc;
    logic               legal;

    ptw_ram #(.WIDTH(32), .ADDR_W(MA)) u_frame_ram (
        .clk   (clk),
        .we    (fm_we),
        .addr  (fm_addr),
        .wdata (fm_wdata),
        .rdata (fm_rdata)
    );

    ptw_ram #(.WIDTH(32), .ADDR_W(VB)) u_swap_ram (
        .clk   (clk),
        .we    (sw_we),
        .addr  (sw_addr),
        .wdata (sw_wdata),
        .rdata (sw_rdata)
    );

    ptw_ram #(.WIDTH(1), .ADDR_W(PB)) u_swap_valid_ram (
        .clk   (clk),
        .we    (sv_we),
        .addr  (sv_addr),
        .wdata (sv_wdata),
        .rdata (sv_rdata)
    );

    // Frame numbers outside the frame memory read as zero words.
    assign entry     = rd_ok_reg ? fm_rdata : 32'd0;
    assign walk_idx  = OB'(64'(va_reg) >> (OB * (L - int'(lv_reg))));
    assign offset    = va_reg[OB-1:0];
    assign page      = PB'(64'(va_reg) >> OB);
    assign slot_addr = faddr(cur_reg, walk_idx);
    assign slot_ok   = in_range(cur_reg);
    assign scan_addr = faddr(frm_reg[d_reg], idx_reg[d_reg]);
    assign scan_ok   = in_range(frm_reg[d_reg]);
    assign top_inc   = {1'b0, top_reg} + 33'd1;
    assign legal     = (64'(req.virt_addr) >> VB) == 64'd0;

    always_comb
    begin
        pg = '0;
        for (int k = 0; k < L; k++)
        begin
            pg = pg | (PB'(idx_reg[k]) << (OB * (L - 1 - k)));
        end
    end

    assign dist_a  = pg - page;
    assign dist_b  = page - pg;
    assign pg_dist = (dist_a < dist_b) ? dist_a : dist_b;

    always_comb
    begin
        state_next        = state_reg;
        rsp_valid_next    = rsp_valid_reg & ~rsp_ready;
        clr_next          = clr_reg;
        lv_next           = lv_reg;
        d_next            = d_reg;
        cnt_next          = cnt_reg;
        max_mode_next     = max_mode_reg;
        have_victim_next  = have_victim_reg;
        unlink_valid_next = unlink_valid_reg;
        rd_ok_next        = rd_ok_reg;
        emp_next          = emp_reg;
        va_next           = va_reg;
        type_next         = type_reg;
        wdata_next        = wdata_reg;
        cur_next          = cur_reg;
        new_next          = new_reg;
        top_next          = top_reg;
        guard_next        = guard_reg;
        victim_page_next  = victim_page_reg;
        victim_dist_next  = victim_dist_reg;
        pick_next         = pick_reg;
        unlink_addr_next  = unlink_addr_reg;
        res_ok_next       = res_ok_reg;
        res_data_next     = res_data_reg;
        rsp_next          = rsp_reg;
        frm_next          = frm_reg;
        idx_next          = idx_reg;
        ptr_next          = ptr_reg;
        fm_we             = 1'b0;
        fm_addr           = '0;
        fm_wdata          = 32'd0;
        sw_we             = 1'b0;
        sw_addr           = '0;
        sw_wdata          = 32'd0;
        sv_we             = 1'b0;
        sv_addr           = '0;
        sv_wdata          = 1'b0;

        case (state_reg)
            S_CLEAR:
            begin
                sv_we    = 1'b1;
                sv_addr  = clr_reg;
                if ((clr_reg >> OB) == '0)
                begin
                    fm_we   = 1'b1;
                    fm_addr = MA'(clr_reg[OB-1:0]);
                end
                clr_next = clr_reg + PB'(1);
                if (clr_reg == '1)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req_valid)
                begin
                    va_next    = req.virt_addr;
                    type_next  = req.req_type;
                    wdata_next = req.write_data;
                    lv_next    = '0;
                    cur_next   = 32'd0;
                    if (legal)
                    begin
                        state_next = S_WALK_RD;
                    end
                    else
                    begin
                        res_ok_next   = 1'b0;
                        res_data_next = 32'sd0;
                        state_next    = S_FIN;
                    end
                end
            end
            S_WALK_RD:
            begin
                fm_addr    = slot_addr;
                rd_ok_next = slot_ok;
                state_next = S_WALK_CHK;
            end
            S_WALK_CHK:
            begin
                if (entry != 32'd0)
                begin
                    new_next   = entry;
                    state_next = S_ADV;
                end
                else
                begin
                    max_mode_next = 1'b1;
                    top_next      = 32'd0;
                    d_next        = '0;
                    frm_next[0]   = 32'd0;
                    idx_next[0]   = '0;
                    emp_next[0]   = 1'b1;
                    ptr_next[0]   = '0;
                    state_next    = S_SCAN_RD;
                end
            end
            S_SCAN_RD:
            begin
                fm_addr    = scan_addr;
                rd_ok_next = scan_ok;
                state_next = S_SCAN_CHK;
            end
            S_SCAN_CHK:
            begin
                state_next = S_SCAN_NEXT;
                if (max_mode_reg && entry > top_reg)
                begin
                    top_next = entry;
                end
                if (entry != 32'd0)
                begin
                    emp_next[d_reg] = 1'b0;
                    if (d_reg != LVL_W'(L - 1))
                    begin
                        d_next                           = d_reg + LVL_W'(1);
                        frm_next[d_reg + LVL_W'(1)]      = entry;
                        idx_next[d_reg + LVL_W'(1)]      = '0;
                        ptr_next[d_reg + LVL_W'(1)]      = scan_addr;
                        emp_next[d_reg + LVL_W'(1)]      = 1'b1;
                        state_next                       = S_SCAN_RD;
                    end
                    else if (!max_mode_reg && (!have_victim_reg || pg_dist > victim_dist_reg))
                    begin
                        have_victim_next  = 1'b1;
                        victim_page_next  = pg;
                        victim_dist_next  = pg_dist;
                        pick_next         = entry;
                        unlink_addr_next  = scan_addr;
                        unlink_valid_next = 1'b1;
                    end
                end
            end
            S_SCAN_NEXT:
            begin
                if (idx_reg[d_reg] != '1)
                begin
                    idx_next[d_reg] = idx_reg[d_reg] + OB'(1);
                    state_next      = S_SCAN_RD;
                end
                else if (!max_mode_reg && emp_reg[d_reg] && frm_reg[d_reg] != guard_reg)
                begin
                    // An empty table other than the one being extended is reclaimed.
                    have_victim_next  = 1'b0;
                    pick_next         = frm_reg[d_reg];
                    unlink_addr_next  = ptr_reg[d_reg];
                    unlink_valid_next = (d_reg != '0);
                    state_next        = S_UNLINK;
                end
                else if (d_reg == '0)
                begin
                    if (max_mode_reg)
                    begin
                        state_next = S_MAX_DONE;
                    end
                    else if (have_victim_reg)
                    begin
                        cnt_next   = '0;
                        state_next = S_CP_RD;
                    end
                    else
                    begin
                        res_ok_next   = 1'b0;
                        res_data_next = 32'sd0;
                        state_next    = S_FIN;
                    end
                end
                else
                begin
                    d_next = d_reg - LVL_W'(1);
                end
            end
            S_MAX_DONE:
            begin
                if (top_inc < 33'(FRAME_COUNT))
                begin
                    new_next   = top_inc[31:0];
                    state_next = S_LINK;
                end
                else
                begin
                    max_mode_next     = 1'b0;
                    guard_next        = cur_reg;
                    have_victim_next  = 1'b0;
                    unlink_valid_next = 1'b0;
                    d_next            = '0;
                    frm_next[0]       = 32'd0;
                    idx_next[0]       = '0;
                    emp_next[0]       = 1'b1;
                    ptr_next[0]       = '0;
                    state_next        = S_SCAN_RD;
                end
            end
            S_CP_RD:
            begin
                fm_addr    = faddr(pick_reg, cnt_reg);
                rd_ok_next = in_range(pick_reg);
                state_next = S_CP_WR;
            end
            S_CP_WR:
            begin
                sw_we    = 1'b1;
                sw_addr  = {victim_page_reg, cnt_reg};
                sw_wdata = entry;
                if (cnt_reg == '1)
                begin
                    state_next = S_SV_SET;
                end
                else
                begin
                    cnt_next   = cnt_reg + OB'(1);
                    state_next = S_CP_RD;
                end
            end
            S_SV_SET:
            begin
                sv_we      = 1'b1;
                sv_addr    = victim_page_reg;
                sv_wdata   = 1'b1;
                state_next = S_UNLINK;
            end
            S_UNLINK:
            begin
                fm_we      = unlink_valid_reg;
                fm_addr    = unlink_addr_reg;
                new_next   = pick_reg;
                state_next = S_LINK;
            end
            S_LINK:
            begin
                fm_we    = slot_ok;
                fm_addr  = slot_addr;
                fm_wdata = new_reg;
                cnt_next = '0;
                if (lv_reg == LVL_W'(L - 1))
                begin
                    state_next = S_SV_RD;
                end
                else
                begin
                    state_next = S_TCLR;
                end
            end
            S_TCLR:
            begin
                fm_we   = in_range(new_reg);
                fm_addr = faddr(new_reg, cnt_reg);
                if (cnt_reg == '1)
                begin
                    state_next = S_ADV;
                end
                else
                begin
                    cnt_next = cnt_reg + OB'(1);
                end
            end
            S_SV_RD:
            begin
                sv_addr    = page;
                state_next = S_SV_CHK;
            end
            S_SV_CHK:
            begin
                cnt_next = '0;
                if (sv_rdata[0])
                begin
                    state_next = S_RS_RD;
                end
                else
                begin
                    state_next = S_ADV;
                end
            end
            S_RS_RD:
            begin
                sw_addr    = {page, cnt_reg};
                state_next = S_RS_WR;
            end
            S_RS_WR:
            begin
                fm_we    = in_range(new_reg);
                fm_addr  = faddr(new_reg, cnt_reg);
                fm_wdata = sw_rdata;
                if (cnt_reg == '1)
                begin
                    state_next = S_SV_CLR;
                end
                else
                begin
                    cnt_next   = cnt_reg + OB'(1);
                    state_next = S_RS_RD;
                end
            end
            S_SV_CLR:
            begin
                sv_we      = 1'b1;
                sv_addr    = page;
                state_next = S_ADV;
            end
            S_ADV:
            begin
                cur_next = new_reg;
                if (lv_reg == LVL_W'(L - 1))
                begin
                    state_next = S_ACC;
                end
                else
                begin
                    lv_next    = lv_reg + LVL_W'(1);
                    state_next = S_WALK_RD;
                end
            end
            S_ACC:
            begin
                fm_addr = faddr(cur_reg, offset);
                if (type_reg == REQ_WRITE)
                begin
                    fm_we         = in_range(cur_reg);
                    fm_wdata      = wdata_reg;
                    res_ok_next   = 1'b1;
                    res_data_next = 32'sd0;
                    state_next    = S_FIN;
                end
                else
                begin
                    rd_ok_next = in_range(cur_reg);
                    state_next = S_ACC_RD;
                end
            end
            S_ACC_RD:
            begin
                res_ok_next   = 1'b1;
                res_data_next = entry;
                state_next    = S_FIN;
            end
            S_FIN:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_valid_next     = 1'b1;
                    rsp_next.access_ok = res_ok_reg;
                    rsp_next.read_data = res_data_reg;
                    state_next         = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_CLEAR;
            rsp_valid_reg    <= 1'b0;
            clr_reg          <= '0;
            lv_reg           <= '0;
            d_reg            <= '0;
            cnt_reg          <= '0;
            max_mode_reg     <= 1'b0;
            have_victim_reg  <= 1'b0;
            unlink_valid_reg <= 1'b0;
            rd_ok_reg        <= 1'b0;
            for (int k = 0; k < L; k++)
            begin
                emp_reg[k] <= 1'b0;
            end
        end
        else
        begin
            state_reg        <= state_next;
            rsp_valid_reg    <= rsp_valid_next;
            clr_reg          <= clr_next;
            lv_reg           <= lv_next;
            d_reg            <= d_next;
            cnt_reg          <= cnt_next;
            max_mode_reg     <= max_mode_next;
            have_victim_reg  <= have_victim_next;
            unlink_valid_reg <= unlink_valid_next;
            rd_ok_reg        <= rd_ok_next;
            emp_reg          <= emp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        va_reg          <= va_next;
        type_reg        <= type_next;
        wdata_reg       <= wdata_next;
        cur_reg         <= cur_next;
        new_reg         <= new_next;
        top_reg         <= top_next;
        guard_reg       <= guard_next;
        victim_page_reg <= victim_page_next;
        victim_dist_reg <= victim_dist_next;
        pick_reg        <= pick_next;
        unlink_addr_reg <= unlink_addr_next;
        res_ok_reg      <= res_ok_next;
        res_data_reg    <= res_data_next;
        rsp_reg         <= rsp_next;
        frm_reg         <= frm_next;
        idx_reg         <= idx_next;
        ptr_reg         <= ptr_next;
    end

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

// File: rtl/core/ptw_ram.sv
// Generic single-port RAM with a registered read.
module ptw_ram #(
    parameter int WIDTH  = 32,
    parameter int ADDR_W = 10
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] addr,
    input  logic [WIDTH-1:0]  wdata,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem_reg [2**ADDR_W];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[addr] <= wdata;
        end
        rdata_reg <= mem_reg[addr];
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/core/ptw_checker.sv
// Port-level checker of the page table walker and its bind to the top level.
`include "page_table_walk_with_eviction_macros.svh"

module ptw_checker
    import ptw_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     req_valid,
    input logic     req_ready,
    input ptw_req_t req,
    input logic     rsp_valid,
    input logic     rsp_ready,
    input ptw_rsp_t rsp
);

    logic [1:0] pend_reg, pend_next;

    always_comb
    begin
        pend_next = pend_reg + 2'(req_valid && req_ready) - 2'(rsp_valid && rsp_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= 2'd0;
        end
        else
        begin
            pend_reg <= pend_next;
        end
    end

    `PTW_ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp))
    `PTW_ASSERT_NOW(a_rsp_has_request, clk, rst_n, rsp_valid, pend_reg != 2'd0)
    `PTW_ASSERT_NOW(a_two_outstanding, clk, rst_n, pend_reg == 2'd2, !req_ready)
    `PTW_ASSERT_NOW(a_clear_after_reset, clk, rst_n, $rose(rst_n), !req_ready)

endmodule

bind page_table_walk_with_eviction ptw_checker u_ptw_checker (.*);

// File: tb/tb_top.sv
// Self-checking testbench for the page table walker with frame eviction.
module tb_top
    import ptw_pkg::*;
;

    localparam int  OFS      = OFFSET_BITS_DEF;
    localparam int  LEVELS   = TABLE_LEVELS_DEF;
    localparam int  FRAMES   = FRAME_COUNT_DEF;
    localparam int  WORDS    = 1 << OFS;
    localparam int  VBITS    = OFS * (LEVELS + 1);
    localparam int  PAGES    = 1 << (OFS * LEVELS);
    localparam int  MEMW     = FRAMES * WORDS;
    localparam int  IDLE_MAX = 200000;

    logic     clk;
    logic     rst_n;
    logic     req_valid;
    logic     req_ready;
    ptw_req_t req;
    logic     rsp_valid;
    logic     rsp_ready;
    ptw_rsp_t rsp;

    page_table_walk_with_eviction DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    logic [31:0] frame_mem [MEMW];
    bit          frame_set [MEMW];
    logic [31:0] swap_mem [PAGES*WORDS];
    bit          swap_set [PAGES*WORDS];
    bit          swap_held [PAGES];

    logic [63:0] wanted_page;
    logic [63:0] parent_frame;
    bit          victim_found;
    logic [63:0] victim_page;
    logic [63:0] taken_frame;
    bit          taken_ok;
    logic [63:0] unlink_slot;
    bit          unlink_ok;

    ptw_rsp_t    pending_rsp [$];
    int          error_count = 0;
    bit          no_idle;
    int          idle_cycles = 0;

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic logic [63:0] mem_read(logic [63:0] a);
        return (a < MEMW) ? 64'(frame_mem[a]) : 64'd0;
    endfunction

    function automatic void mem_write(logic [63:0] a, logic [31:0] v, bit known);
        if (a < MEMW)
        begin
            frame_mem[a] = v;
            frame_set[a] = known;
        end
    endfunction

    function automatic logic [63:0] highest_frame(logic [63:0] frame, int depth);
        logic [63:0] top;
        logic [63:0] e;
        logic [63:0] sub;
        top = frame;
        for (int i = 0; i < WORDS; i++)
        begin
            e = mem_read(frame * WORDS + i);
            if (e > top)
                top = e;
            if (e != 0 && depth > 1)
            begin
                sub = highest_frame(e, depth - 1);
                if (sub > top)
                    top = sub;
            end
        end
        return top;
    endfunction

    function automatic logic [63:0] page_distance(logic [63:0] a, logic [63:0] b);
        logic [63:0] d;
        logic [63:0] w;
        d = (a > b) ? a - b : b - a;
        w = PAGES - d;
        return (d < w) ? d : w;
    endfunction

    // Returns 0 once an empty table has been chosen for reuse.
    function automatic bit scan_tables(logic [63:0] ptr, bit ptr_ok, logic [63:0] frame,
                                       logic [63:0] base, int depth);
        bit          empty;
        logic [63:0] slot;
        logic [63:0] e;
        logic [63:0] pg;
        empty = 1'b1;
        for (int i = 0; i < WORDS; i++)
        begin
            slot = frame * WORDS + i;
            e = mem_read(slot);
            if (e == 0)
                continue;
            empty = 1'b0;
            if (depth > 1)
            begin
                if (!scan_tables(slot, 1'b1, e, base + (64'(i) << (OFS * (depth - 1))),
                                 depth - 1))
                    return 1'b0;
            end
            else
            begin
                pg = base + i;
                if (!victim_found || page_distance(victim_page, wanted_page)
                                     < page_distance(pg, wanted_page))
                begin
                    victim_found = 1'b1;
                    victim_page  = pg;
                    taken_frame  = e;
                    taken_ok     = 1'b1;
                    unlink_slot  = slot;
                    unlink_ok    = 1'b1;
                end
            end
        end
        if (empty)
        begin
            if (frame == parent_frame)
                return 1'b1;
            victim_found = 1'b0;
            taken_frame  = frame;
            taken_ok     = 1'b1;
            unlink_slot  = ptr;
            unlink_ok    = ptr_ok;
            return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic bit reclaim_frame(logic [63:0] page, logic [63:0] parent,
                                         output logic [63:0] frame);
        logic [63:0] dst;
        wanted_page  = page;
        parent_frame = parent;
        victim_found = 1'b0;
        taken_ok     = 1'b0;
        unlink_ok    = 1'b0;
        frame        = 0;
        if (scan_tables(0, 1'b0, 0, 0, LEVELS))
        begin
            if (!victim_found)
                return 1'b0;
            for (int i = 0; i < WORDS; i++)
            begin
                dst = (victim_page % PAGES) * WORDS + i;
                swap_mem[dst] = 32'(mem_read(taken_frame * WORDS + i));
                swap_set[dst] = (taken_frame * WORDS + i < MEMW) ?
                                frame_set[taken_frame * WORDS + i] : 1'b1;
            end
            swap_held[victim_page % PAGES] = 1'b1;
        end
        if (!taken_ok)
            return 1'b0;
        if (unlink_ok)
            mem_write(unlink_slot, 32'd0, 1'b1);
        frame = taken_frame;
        return 1'b1;
    endfunction

    // Walks the table as the block does. A read of a word never written is
    // turned into a write, which allocates the same way.
    task automatic translate_access(inout ptw_req_t r, output ptw_rsp_t x);
        logic [63:0] va;
        logic [63:0] page;
        logic [63:0] cur;
        logic [63:0] slot;
        logic [63:0] fr;
        logic [63:0] pa;
        x  = '0;
        va = 64'(r.virt_addr);
        if ((va >> VBITS) != 0)
            return;
        page = (va >> OFS) % PAGES;
        cur  = 0;
        for (int lv = 0; lv < LEVELS; lv++)
        begin
            slot = cur * WORDS + ((va >> (OFS * (LEVELS - lv))) % WORDS);
            fr = mem_read(slot);
            if (fr == 0)
            begin
                fr = highest_frame(0, LEVELS) + 1;
                if (fr >= FRAMES)
                begin
                    if (!reclaim_frame(page, cur, fr))
                        return;
                end
                mem_write(slot, fr[31:0], 1'b1);
                if (lv < LEVELS - 1)
                begin
                    for (int i = 0; i < WORDS; i++)
                        mem_write(fr * WORDS + i, 32'd0, 1'b1);
                end
                else if (swap_held[page])
                begin
                    for (int i = 0; i < WORDS; i++)
                        mem_write(fr * WORDS + i, swap_mem[page * WORDS + i],
                                  swap_set[page * WORDS + i]);
                    swap_held[page] = 1'b0;
                end
            end
            cur = fr;
        end
        pa = cur * WORDS + (va % WORDS);
        if (r.req_type == REQ_READ && !(pa < MEMW && frame_set[pa]))
        begin
            r.req_type   = REQ_WRITE;
            r.write_data = $urandom;
        end
        if (r.req_type == REQ_WRITE)
            mem_write(pa, r.write_data, 1'b1);
        else
            x.read_data = 32'(mem_read(pa));
        x.access_ok = 1'b1;
    endtask

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    task automatic send_request(logic kind, logic [31:0] addr, logic [31:0] data);
        ptw_req_t r;
        ptw_rsp_t x;
        int       gap;
        r.req_type   = kind;
        r.virt_addr  = addr;
        r.write_data = data;
        translate_access(r, x);
        pending_rsp.push_back(x);
        gap = no_idle ? 0 : $urandom_range(0, 10);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req       <= r;
        req_valid <= 1'b1;
        do
            @(posedge clk);
        while (!(req_valid && req_ready));
    endtask

    always
    begin
        int n;
        n = no_idle ? 0 : $urandom_range(0, 10);
        if (n > 0)
        begin
            rsp_ready <= 1'b0;
            repeat (n) @(posedge clk);
        end
        rsp_ready <= 1'b1;
        do
            @(posedge clk);
        while (!(rsp_valid && rsp_ready));
    end

    always @(posedge clk)
    begin
        ptw_rsp_t x;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (pending_rsp.size() == 0)
                report_mismatch("unexpected response", rsp.read_data, 32'd0);
            else
            begin
                x = pending_rsp.pop_front();
                if (rsp.access_ok !== x.access_ok)
                    report_mismatch("access_ok", 32'(rsp.access_ok), 32'(x.access_ok));
                if (rsp.read_data !== x.read_data)
                    report_mismatch("read_data", rsp.read_data, x.read_data);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles > IDLE_MAX)
            begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    task automatic test_illegal_addresses();
        send_request(REQ_READ, 32'h0001_0000, 32'd0);
        send_request(REQ_WRITE, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
        send_request(REQ_READ, 32'h8000_0000, 32'd0);
        for (int i = 0; i < 4; i++)
            send_request(1'($urandom_range(0, 1)), $urandom | 32'h0001_0000, $urandom);
    endtask

    task automatic test_edge_accesses();
        send_request(REQ_WRITE, 32'h0000_0000, 32'h8000_0000);
        send_request(REQ_READ, 32'h0000_0000, 32'd0);
        send_request(REQ_WRITE, 32'h0000_FFFF, 32'h7FFF_FFFF);
        send_request(REQ_READ, 32'h0000_FFFF, 32'hFFFF_FFFF);
        send_request(REQ_WRITE, 32'h0000_8001, 32'hFFFF_FFFF);
        send_request(REQ_WRITE, 32'h0000_8001, 32'h0000_0000);
        send_request(REQ_READ, 32'h0000_8001, 32'd0);
        send_request(REQ_READ, 32'h0000_7FF0, 32'd0);
    endtask

    task automatic test_working_set(int count);
        logic [11:0] pool [24];
        foreach (pool[k])
            pool[k] = 12'($urandom);
        for (int n = 0; n < count; n++)
            send_request(1'($urandom_range(0, 1)),
                         {16'd0, pool[$urandom_range(0, 23)], 4'($urandom)}, $urandom);
    endtask

    task automatic test_scattered(int count);
        for (int n = 0; n < count; n++)
        begin
            if ($urandom_range(0, 9) == 0)
                send_request(1'($urandom_range(0, 1)), $urandom | 32'h0001_0000, $urandom);
            else
                send_request(1'($urandom_range(0, 1)), {16'd0, 16'($urandom)}, $urandom);
        end
    endtask

    initial
    begin
        req_valid   = 1'b0;
        req         = '0;
        rst_n       = 1'b0;
        no_idle     = 1'b0;
        foreach (frame_mem[a])
        begin
            frame_mem[a] = '0;
            frame_set[a] = (a < WORDS);
        end
        foreach (swap_held[p])
            swap_held[p] = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        test_illegal_addresses();
        test_edge_accesses();
        test_working_set(100);
        no_idle = 1'b1;
        test_working_set(40);
        no_idle = 1'b0;
        test_scattered(100);
        no_idle = 1'b1;
        test_scattered(40);
        no_idle = 1'b0;
        req_valid <= 1'b0;

        while (pending_rsp.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (error_count == 0 && pending_rsp.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
